// ===== hdl/assert_macros.svh =====
// Assertion macros for the order book RTL; lobm_ctrl is the only file that uses them.
// Needs a clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== hdl/lobm_pkg.sv =====
// Shared types and codes for the order book matcher.
// No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;
    localparam int DEF_BOOK_SLOTS = 32;
    localparam int IDX_W = 6;
    localparam int ARR_W = 48;
    localparam int SUM_W = 33;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MODIFY = 2'd2,
        OP_EOD    = 2'd3
    } op_t;

    localparam logic [2:0] KIND_GTC = 3'd0;
    localparam logic [2:0] KIND_FAK = 3'd1;
    localparam logic [2:0] KIND_FOK = 3'd2;
    localparam logic [2:0] KIND_GFD = 3'd3;
    localparam logic [2:0] KIND_MKT = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_NO_LIQ  = 3'd2;
    localparam logic [2:0] ST_FAK     = 3'd3;
    localparam logic [2:0] ST_FOK     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [31:0]      id;
        logic             side;
        logic [2:0]       kind;
        logic [31:0]      price;
        logic [31:0]      qty;
        logic [ARR_W-1:0] arrival;
        logic             a_en;
        logic [IDX_W-1:0] a_idx;
        logic             b_en;
        logic [IDX_W-1:0] b_idx;
        logic             dec;
        logic [31:0]      dec_qty;
        logic             eod;
    } cell_cmd_t;

    typedef struct packed {
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
    } probe_ctx_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [31:0]      id;
        logic [2:0]       kind;
        logic [31:0]      price;
        logic [ARR_W-1:0] arrival;
        logic [31:0]      rem;
    } best_t;

    typedef struct packed {
        best_t            bid;
        best_t            ask;
        logic             wbid_vld;
        logic [31:0]      wbid_price;
        logic             wask_vld;
        logic [31:0]      wask_price;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [2:0]       found_kind;
        logic             free_vld;
        logic [IDX_W-1:0] free_idx;
        logic             fok_any;
        logic [SUM_W-1:0] fok_sum;
    } probe_t;

    localparam probe_t PROBE_EMPTY = '0;
endpackage

// ===== hdl/lobm_cell.sv =====
// One book slot plus its stage of the search chain.
// Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_cell import lobm_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  probe_ctx_t ctx,
    input  probe_t     probe_in,
    output probe_t     probe_out
);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic             valid_reg, valid_next;
    logic [31:0]      id_reg;
    logic             side_reg;
    logic [2:0]       kind_reg;
    logic [31:0]      price_reg;
    logic [31:0]      rem_reg;
    logic [ARR_W-1:0] arr_reg;
    probe_t           probe_reg, probe_next;
    logic [SUM_W:0]   sum_w;
    logic             hit;
    logic             in_range;

    assign probe_out = probe_reg;
    assign hit = (cmd.a_en && cmd.a_idx == MY_IDX) || (cmd.b_en && cmd.b_idx == MY_IDX);
    assign sum_w = (SUM_W+1)'(probe_in.fok_sum) + (SUM_W+1)'(rem_reg);
    assign in_range = ctx.side ? ($signed(price_reg) >= $signed(ctx.price))
                               : ($signed(price_reg) <= $signed(ctx.price));

    // fold this slot into the running search result
    always_comb
    begin
        probe_next = probe_in;
        if (valid_reg)
        begin
            if (!probe_in.found && id_reg == ctx.id)
            begin
                probe_next.found      = 1'b1;
                probe_next.found_idx  = MY_IDX;
                probe_next.found_kind = kind_reg;
            end
            if (!side_reg)
            begin
                if (!probe_in.bid.vld || $signed(price_reg) > $signed(probe_in.bid.price) ||
                    (price_reg == probe_in.bid.price && arr_reg < probe_in.bid.arrival))
                begin
                    probe_next.bid = '{1'b1, MY_IDX, id_reg, kind_reg, price_reg, arr_reg,
                                       rem_reg};
                end
                if (!probe_in.wbid_vld || $signed(price_reg) < $signed(probe_in.wbid_price))
                begin
                    probe_next.wbid_vld   = 1'b1;
                    probe_next.wbid_price = price_reg;
                end
            end
            else
            begin
                if (!probe_in.ask.vld || $signed(price_reg) < $signed(probe_in.ask.price) ||
                    (price_reg == probe_in.ask.price && arr_reg < probe_in.ask.arrival))
                begin
                    probe_next.ask = '{1'b1, MY_IDX, id_reg, kind_reg, price_reg, arr_reg,
                                       rem_reg};
                end
                if (!probe_in.wask_vld || $signed(price_reg) > $signed(probe_in.wask_price))
                begin
                    probe_next.wask_vld   = 1'b1;
                    probe_next.wask_price = price_reg;
                end
            end
            if (side_reg != ctx.side && in_range)
            begin
                probe_next.fok_any = 1'b1;
                probe_next.fok_sum = sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
            end
        end
        else if (!probe_in.free_vld)
        begin
            probe_next.free_vld = 1'b1;
            probe_next.free_idx = MY_IDX;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.wr_en && cmd.wr_idx == MY_IDX)
            valid_next = 1'b1;
        else if (hit)
            valid_next = cmd.dec ? (rem_reg != cmd.dec_qty) : 1'b0;
        else if (cmd.eod && kind_reg == KIND_GFD)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            probe_reg <= PROBE_EMPTY;
        end
        else
        begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_idx == MY_IDX)
        begin
            id_reg    <= cmd.id;
            side_reg  <= cmd.side;
            kind_reg  <= cmd.kind;
            price_reg <= cmd.price;
            rem_reg   <= cmd.qty;
            arr_reg   <= cmd.arrival;
        end
        else if (hit && cmd.dec)
        begin
            rem_reg <= rem_reg - cmd.dec_qty;
        end
    end
endmodule

// ===== hdl/lobm_ctrl.sv =====
// Sequencer: decodes items, reads the settled search chain, issues slot
// commands and drives the result register. Depends on lobm_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lobm_ctrl import lobm_pkg::*; #(
    parameter int BOOK_SLOTS = DEF_BOOK_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_op,
    input  logic [31:0] in_id,
    input  logic        in_side,
    input  logic [2:0]  in_kind,
    input  logic [31:0] in_price,
    input  logic [31:0] in_qty,
    input  probe_t      probe,
    output cell_cmd_t   cmd,
    output probe_ctx_t  ctx,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_is_trade,
    output logic [31:0] out_buy_id,
    output logic [31:0] out_sell_id,
    output logic [31:0] out_buy_price,
    output logic [31:0] out_sell_price,
    output logic [31:0] out_qty,
    output logic [2:0]  out_status,
    output logic        out_last
);
    localparam int CNT_W = $clog2(BOOK_SLOTS + 1);
    localparam logic [CNT_W-1:0] SETTLE = CNT_W'(BOOK_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_MATCH  = 5'b00100,
        S_EMIT   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    op_t              op_reg, op_next;
    logic [31:0]      id_reg, id_next;
    logic             side_reg, side_next;
    logic [2:0]       kind_reg, kind_next;
    logic [31:0]      price_reg, price_next;
    logic [31:0]      qty_reg, qty_next;
    logic [ARR_W-1:0] arr_reg, arr_next;
    logic [2:0]       status_reg, status_next;

    logic             ov_reg, ov_next;
    logic             o_trade_reg, o_trade_next;
    logic [31:0]      o_bid_reg, o_bid_next;
    logic [31:0]      o_sid_reg, o_sid_next;
    logic [31:0]      o_bp_reg, o_bp_next;
    logic [31:0]      o_sp_reg, o_sp_next;
    logic [31:0]      o_q_reg, o_q_next;
    logic [2:0]       o_st_reg, o_st_next;
    logic             o_last_reg, o_last_next;

    logic             settled;
    logic             out_free;
    logic             crosses;
    logic [31:0]      fill_q;
    logic             opp_worst_vld;
    logic [31:0]      opp_worst_price;
    best_t            opp_best;
    logic             fak_bad;

    assign settled  = (cnt_reg == SETTLE);
    assign out_free = !ov_reg || out_ready;
    assign crosses  = probe.bid.vld && probe.ask.vld &&
                      ($signed(probe.bid.price) >= $signed(probe.ask.price));
    assign fill_q   = (probe.bid.rem < probe.ask.rem) ? probe.bid.rem : probe.ask.rem;
    assign opp_worst_vld   = side_reg ? probe.wbid_vld : probe.wask_vld;
    assign opp_worst_price = side_reg ? probe.wbid_price : probe.wask_price;
    assign opp_best = side_reg ? probe.bid : probe.ask;
    assign fak_bad  = !opp_best.vld ||
                      (side_reg ? ($signed(price_reg) > $signed(opp_best.price))
                                : ($signed(price_reg) < $signed(opp_best.price)));

    assign in_ready       = (state_reg == S_IDLE);
    assign ctx            = '{id_reg, side_reg, price_reg};
    assign out_valid      = ov_reg;
    assign out_is_trade   = o_trade_reg;
    assign out_buy_id     = o_bid_reg;
    assign out_sell_id    = o_sid_reg;
    assign out_buy_price  = o_bp_reg;
    assign out_sell_price = o_sp_reg;
    assign out_qty        = o_q_reg;
    assign out_status     = o_st_reg;
    assign out_last       = o_last_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = (cnt_reg == SETTLE) ? cnt_reg : cnt_reg + 1'b1;
        op_next      = op_reg;
        id_next      = id_reg;
        side_next    = side_reg;
        kind_next    = kind_reg;
        price_next   = price_reg;
        qty_next     = qty_reg;
        arr_next     = arr_reg;
        status_next  = status_reg;
        cmd          = '0;
        ov_next      = ov_reg && !out_ready;
        o_trade_next = o_trade_reg;
        o_bid_next   = o_bid_reg;
        o_sid_next   = o_sid_reg;
        o_bp_next    = o_bp_reg;
        o_sp_next    = o_sp_reg;
        o_q_next     = o_q_reg;
        o_st_next    = o_st_reg;
        o_last_next  = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op_t'(in_op);
                    id_next     = in_id;
                    side_next   = in_side;
                    kind_next   = (in_kind > KIND_MKT) ? KIND_GTC : in_kind;
                    price_next  = in_price;
                    qty_next    = in_qty;
                    cnt_next    = '0;
                    status_next = ST_OK;
                    if (op_t'(in_op) == OP_EOD)
                    begin
                        cmd.eod    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (settled)
                begin
                    cnt_next = '0;
                    case (op_reg)
                        OP_CANCEL:
                        begin
                            if (!probe.found)
                                status_next = ST_UNKNOWN;
                            cmd.a_en   = probe.found;
                            cmd.a_idx  = probe.found_idx;
                            state_next = S_DONE;
                        end
                        OP_MODIFY:
                        begin
                            if (!probe.found)
                            begin
                                status_next = ST_UNKNOWN;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                // drop the old order, then run the add path with its kind
                                cmd.a_en  = 1'b1;
                                cmd.a_idx = probe.found_idx;
                                kind_next = probe.found_kind;
                                op_next   = OP_ADD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                            if (probe.found)
                                status_next = ST_DUP;
                            else if (kind_reg == KIND_MKT && !opp_worst_vld)
                                status_next = ST_NO_LIQ;
                            else if (kind_reg == KIND_FAK && fak_bad)
                                status_next = ST_FAK;
                            else if (kind_reg == KIND_FOK &&
                                     !(probe.fok_any && probe.fok_sum >= SUM_W'(qty_reg)))
                                status_next = ST_FOK;
                            else if (!probe.free_vld)
                                status_next = ST_FULL;
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_idx  = probe.free_idx;
                                cmd.id      = id_reg;
                                cmd.side    = side_reg;
                                cmd.kind    = (kind_reg == KIND_MKT) ? KIND_GTC : kind_reg;
                                cmd.price   = (kind_reg == KIND_MKT) ? opp_worst_price
                                                                     : price_reg;
                                cmd.qty     = qty_reg;
                                cmd.arrival = arr_reg;
                                arr_next    = arr_reg + 1'b1;
                                state_next  = S_MATCH;
                            end
                        end
                    endcase
                end
            end
            S_MATCH:
            begin
                if (settled)
                begin
                    if (crosses)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // fill-and-kill orders left at the head of a side are dropped
                        cmd.a_en   = probe.bid.vld && probe.bid.kind == KIND_FAK;
                        cmd.a_idx  = probe.bid.idx;
                        cmd.b_en   = probe.ask.vld && probe.ask.kind == KIND_FAK;
                        cmd.b_idx  = probe.ask.idx;
                        state_next = S_DONE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_trade_next = 1'b1;
                    o_bid_next   = probe.bid.id;
                    o_sid_next   = probe.ask.id;
                    o_bp_next    = probe.bid.price;
                    o_sp_next    = probe.ask.price;
                    o_q_next     = fill_q;
                    o_st_next    = ST_OK;
                    o_last_next  = 1'b0;
                    cmd.a_en     = 1'b1;
                    cmd.a_idx    = probe.bid.idx;
                    cmd.b_en     = 1'b1;
                    cmd.b_idx    = probe.ask.idx;
                    cmd.dec      = 1'b1;
                    cmd.dec_qty  = fill_q;
                    cnt_next     = '0;
                    state_next   = S_MATCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_trade_next = 1'b0;
                    o_bid_next   = '0;
                    o_sid_next   = '0;
                    o_bp_next    = '0;
                    o_sp_next    = '0;
                    o_q_next     = '0;
                    o_st_next    = status_reg;
                    o_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            arr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            arr_reg   <= arr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        side_reg    <= side_next;
        kind_reg    <= kind_next;
        price_reg   <= price_next;
        qty_reg     <= qty_next;
        status_reg  <= status_next;
        o_trade_reg <= o_trade_next;
        o_bid_reg   <= o_bid_next;
        o_sid_reg   <= o_sid_next;
        o_bp_reg    <= o_bp_next;
        o_sp_reg    <= o_sp_next;
        o_q_reg     <= o_q_next;
        o_st_reg    <= o_st_next;
        o_last_reg  <= o_last_next;
    end

    `ASSERT_IMPL(a_fill_two_slots, cmd.dec, cmd.a_idx != cmd.b_idx)
    `ASSERT_IMPL(a_emit_crosses, state_reg == S_EMIT, crosses)
    `ASSERT_CLK(a_cnt_range, cnt_reg <= SETTLE)
    `ASSERT_IMPL(a_accept_leaves_idle, in_valid && in_ready, ##1 state_reg != S_IDLE)
endmodule

// ===== hdl/limit_order_book_matcher_core.sv =====
// Top level of the order book matcher: slot chain plus sequencer.
// Depends on lobm_pkg, lobm_cell, lobm_ctrl.
`timescale 1ns / 1ps
// Usage:
//   Slave channel s_*: one item per order operation. s_tuser carries op
//   (add, cancel, modify, end of day); s_tdata carries the order fields.
//   Master channel m_*: zero or more trade records (m_tuser = 1), then one
//   completion record with the status and m_tlast = 1.
// Structure: BOOK_SLOTS cells in a row, each holding one resting order and
//   one registered stage of a search that passes best bid/ask, worst
//   prices, id match, first free slot and fill-or-kill depth to the next
//   cell every cycle. After any book change the result is valid at the end
//   of the row once it has passed the registered stages behind the changed cell.
// Sequence, from the accepting edge to the completion record: cancel
//   waits for one settled search; add waits for one, writes the order and
//   waits for another; modify first drops the old order and then runs the
//   add path; each fill waits for another search; end of day goes straight to the completion record.
// One item is in work at a time; s_tready is high while the sequencer is
//   free, even while the last completion record waits in the output register.
// Stall: a low m_tready freezes the sequencer at the next record; nothing
//   is dropped. Reset empties the book and zeroes the arrival counter.
module limit_order_book_matcher_core import lobm_pkg::*; #(
    parameter int BOOK_SLOTS = DEF_BOOK_SLOTS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // op
    input  logic [103:0] s_tdata,   // order_id, side, order_kind, limit_price, quantity
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,   // is_trade
    output logic [167:0] m_tdata,   // buy_id, sell_id, buy_price, sell_price,
                                    // trade_quantity, status
    output logic         m_tlast    // last
);
    probe_t     chain [0:BOOK_SLOTS];
    cell_cmd_t  cmd;
    probe_ctx_t ctx;

    logic [31:0] o_bid;
    logic [31:0] o_sid;
    logic [31:0] o_bp;
    logic [31:0] o_sp;
    logic [31:0] o_q;
    logic [2:0]  o_st;

    // the head of the chain always sees an empty search
    assign chain[0] = PROBE_EMPTY;

    genvar g;
    generate
        for (g = 0; g < BOOK_SLOTS; g++)
        begin : g_cell
            lobm_cell #(.IDX(g)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .ctx       (ctx),
                .probe_in  (chain[g]),
                .probe_out (chain[g+1])
            );
        end
    endgenerate

    lobm_ctrl #(.BOOK_SLOTS(BOOK_SLOTS)) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_id          (s_tdata[31:0]),
        .in_side        (s_tdata[32]),
        .in_kind        (s_tdata[35:33]),
        .in_price       (s_tdata[67:36]),
        .in_qty         (s_tdata[99:68]),
        .probe          (chain[BOOK_SLOTS]),
        .cmd            (cmd),
        .ctx            (ctx),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_is_trade   (m_tuser),
        .out_buy_id     (o_bid),
        .out_sell_id    (o_sid),
        .out_buy_price  (o_bp),
        .out_sell_price (o_sp),
        .out_qty        (o_q),
        .out_status     (o_st),
        .out_last       (m_tlast)
    );

    assign m_tdata = {5'b0, o_st, o_q, o_sp, o_bp, o_sid, o_bid};
endmodule
